### design/rls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_pkg
// Shared widths, constants and controller/datapath types for the radial
// Laplacian stencil.
// ----------------------------------------------------------------------------
package rls_pkg;

    localparam int C_FRAC       = 16;
    localparam int C_MAX_POINTS = 65536;
    localparam int C_LINE_CAP   = (C_MAX_POINTS < 65536) ? C_MAX_POINTS : 65536;

    localparam int SMP_W      = 32;
    localparam int IH_W       = 31;
    localparam int RS_W       = 31;
    localparam int NP_W       = 17;
    localparam int IDX_W      = 16;
    localparam int DMAG_W     = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W  = 64;
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = (PROD_W - C_FRAC + CHUNK_W - 1) / CHUNK_W;
    localparam int CHK_W   = 2;
    localparam int MX_W    = N_CHUNK * CHUNK_W;
    localparam int PP_W    = CHUNK_W + IH_W;
    localparam int ACC_W   = MX_W + IH_W;
    localparam int RP_W    = IDX_W + RS_W;
    localparam int RAD_W   = RP_W + 2;
    localparam int RMAG_W  = RAD_W - 1;
    localparam int DEN_W   = RMAG_W + 1;
    localparam int QUO_W   = PROD_W;
    localparam int TERM_W  = 64;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [ACC_W-1:0]  C_TERM_LIM = ACC_W'(64'h4000_0000_0000_0000);
    localparam logic [SMP_W-1:0]  C_SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0]  C_SAT_MIN  = 32'h8000_0000;

    localparam logic [IH_W-1:0]   C_INV_H_RST   = 31'd65536;
    localparam logic [SMP_W-1:0]  C_R_FIRST_RST = 32'd0;
    localparam logic [RS_W-1:0]   C_R_STEP_RST  = 31'd65536;
    localparam logic [NP_W-1:0]   C_N_POINTS_RST = 17'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_H    = 2'd0,
        CFG_R_FIRST  = 2'd1,
        CFG_R_STEP   = 2'd2,
        CFG_N_POINTS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MS_RADIUS = 2'd0,
        MS_D2     = 2'd1,
        MS_T      = 2'd2,
        MS_D1     = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic             accept;
        logic             mload;
        logic             mpp;
        logic             macc;
        logic             mstore;
        logic             dload;
        logic             dstep;
        logic             sum;
        logic             load_res;
        logic             load_end;
        t_mul_sel         mul_sel;
        logic [CHK_W-1:0] chunk;
    } t_cmd;

    typedef struct packed {
        logic acc_interior;
        logic acc_first;
        logic acc_last;
        logic last_pending;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### design/rls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer: chunked multiplies, radix-2 divide, sum and result beats.
// ----------------------------------------------------------------------------
module rls_ctrl
    import rls_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MLOAD  = 10'b00_0000_0010,
        S_MPP    = 10'b00_0000_0100,
        S_MACC   = 10'b00_0000_1000,
        S_MSTORE = 10'b00_0001_0000,
        S_DLOAD  = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_SUM    = 10'b00_1000_0000,
        S_PUT1   = 10'b01_0000_0000,
        S_PUT2   = 10'b10_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_mul_sel         r_sel, n_sel;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.mul_sel = r_sel;
        o_cmd.chunk   = r_cnt[CHK_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_sel = MS_RADIUS;
                    if (i_status.acc_interior) begin
                        n_state = S_MLOAD;
                    end else if (i_status.acc_first) begin
                        n_state = S_PUT1;
                    end else if (i_status.acc_last) begin
                        n_state = S_PUT2;
                    end
                end
            end
            S_MLOAD: begin
                o_cmd.mload = 1'b1;
                n_cnt   = '0;
                n_state = S_MPP;
            end
            S_MPP: begin
                o_cmd.mpp = 1'b1;
                n_state   = S_MACC;
            end
            S_MACC: begin
                o_cmd.macc = 1'b1;
                if (r_cnt[CHK_W-1:0] == CHK_W'(N_CHUNK - 1)) begin
                    n_state = S_MSTORE;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_MPP;
                end
            end
            S_MSTORE: begin
                o_cmd.mstore = 1'b1;
                if (r_sel == MS_D1) begin
                    n_state = S_DLOAD;
                end else begin
                    n_sel   = t_mul_sel'(r_sel + 2'd1);
                    n_state = S_MLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.dload = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SUM;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_PUT1;
            end
            S_PUT1: begin
                if (i_status.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state = i_status.last_pending ? S_PUT2 : S_IDLE;
                end
            end
            S_PUT2: begin
                if (i_status.out_free) begin
                    o_cmd.load_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= MS_RADIUS;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule
`default_nettype wire

### design/rls_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_datapath
// Config registers, sample window, line counter, chunked multiplier,
// restoring divider, saturation and the output register.
// ----------------------------------------------------------------------------
module rls_datapath
    import rls_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [SMP_W-1:0]      i_sample,
    input  wire logic                  i_out_ready,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [SMP_W-1:0]           o_lap_value,
    output logic [IDX_W-1:0]           o_result_index,
    output logic                       o_line_end,
    output logic                       o_saturated
);

    logic [IH_W-1:0]   r_inv_h;
    logic [SMP_W-1:0]  r_r_first;
    logic [RS_W-1:0]   r_r_step;
    logic [NP_W-1:0]   r_n_points;

    logic [SMP_W-1:0]  r_older, r_middle;
    logic [NP_W-1:0]   r_count, n_count;
    logic [NP_W-1:0]   w_lim, w_cnt_eff;

    logic [DMAG_W-1:0] r_d2_mag, r_d1_mag;
    logic              r_d2_neg, r_d1_neg;
    logic [IDX_W-1:0]  r_idx, r_end_idx;
    logic              r_prev_zero, r_is_last;

    logic signed [DMAG_W:0]   w_d2;
    logic signed [DMAG_W:0]   w_d2_abs;
    logic signed [DMAG_W:0]   w_d1;
    logic signed [DMAG_W:0]   w_d1_abs;

    logic [MX_W-1:0]   r_mx;
    logic [IH_W-1:0]   r_my;
    logic [PP_W-1:0]   r_pp;
    logic [ACC_W-1:0]  r_acc;

    logic signed [RAD_W-1:0]  r_rad;
    logic [RAD_W-1:0]         w_rad_abs;
    logic signed [TERM_W-1:0] r_term1;
    logic                     r_sat1;
    logic [TERM_W-1:0]        w_p;

    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [DEN_W:0]    w_sh, w_diff;

    logic signed [TERM_W-1:0] r_sum, w_term2;
    logic                     w_sum_ok;
    logic [SMP_W-1:0]         w_res_val;
    logic                     w_res_sat;

    // line position of the incoming beat
    always_comb begin
        w_lim = (r_n_points == '0) ? NP_W'(1) : r_n_points;
        if (w_lim > NP_W'(C_LINE_CAP)) begin
            w_lim = NP_W'(C_LINE_CAP);
        end
        w_cnt_eff = (r_count >= w_lim) ? '0 : r_count;
        o_status.acc_interior = (w_cnt_eff > NP_W'(1));
        o_status.acc_first    = (w_cnt_eff == NP_W'(1));
        o_status.acc_last     = (w_cnt_eff == w_lim - NP_W'(1));
        o_status.last_pending = r_is_last;
        o_status.out_free     = !o_out_valid || i_out_ready;
        n_count = o_status.acc_last ? '0 : w_cnt_eff + NP_W'(1);
    end

    always_comb begin
        w_d2 = $signed({{2{r_older[SMP_W-1]}}, r_older})
             + $signed({{2{i_sample[SMP_W-1]}}, i_sample})
             - $signed({r_middle[SMP_W-1], r_middle, 1'b0});
        w_d2_abs = w_d2[DMAG_W] ? -w_d2 : w_d2;
        w_d1 = $signed({{2{i_sample[SMP_W-1]}}, i_sample})
             - $signed({{2{r_older[SMP_W-1]}}, r_older});
        w_d1_abs = w_d1[DMAG_W] ? -w_d1 : w_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_h    <= C_INV_H_RST;
            r_r_first  <= C_R_FIRST_RST;
            r_r_step   <= C_R_STEP_RST;
            r_n_points <= C_N_POINTS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_H:    r_inv_h    <= i_cfg_data[IH_W-1:0];
                CFG_R_FIRST:  r_r_first  <= i_cfg_data[SMP_W-1:0];
                CFG_R_STEP:   r_r_step   <= i_cfg_data[RS_W-1:0];
                CFG_N_POINTS: r_n_points <= i_cfg_data[NP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_middle    <= '0;
            r_count     <= '0;
            r_is_last   <= 1'b0;
            r_prev_zero <= 1'b0;
        end else if (i_cmd.accept) begin
            r_older     <= r_middle;
            r_middle    <= i_sample;
            r_count     <= n_count;
            r_is_last   <= o_status.acc_last;
            r_prev_zero <= o_status.acc_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_d2_mag  <= w_d2_abs[DMAG_W-1:0];
            r_d2_neg  <= w_d2[DMAG_W];
            r_d1_mag  <= w_d1_abs[DMAG_W-1:0];
            r_d1_neg  <= w_d1[DMAG_W];
            r_idx     <= IDX_W'(w_cnt_eff - NP_W'(1));
            r_end_idx <= w_cnt_eff[IDX_W-1:0];
        end
    end

    // multiplier: one chunk of the wide operand per product beat
    always_comb begin
        w_p = (r_acc > C_TERM_LIM) ? TERM_W'(C_TERM_LIM) : TERM_W'(r_acc[ACC_W-1:C_FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mload) begin
            r_acc <= '0;
            case (i_cmd.mul_sel)
                MS_RADIUS: begin
                    r_mx <= MX_W'(r_idx);
                    r_my <= r_r_step;
                end
                MS_D2: begin
                    r_mx <= MX_W'(r_d2_mag);
                    r_my <= r_inv_h;
                end
                MS_T: begin
                    r_mx <= MX_W'(r_acc[PROD_W-1:C_FRAC]);
                    r_my <= r_inv_h;
                end
                MS_D1: begin
                    r_mx <= MX_W'(r_d1_mag);
                    r_my <= r_inv_h;
                end
                default: ;
            endcase
        end
        if (i_cmd.mpp) begin
            r_pp <= PP_W'(r_mx[i_cmd.chunk * CHUNK_W +: CHUNK_W]) * PP_W'(r_my);
        end
        if (i_cmd.macc) begin
            r_acc <= r_acc + (ACC_W'(r_pp) << (CHUNK_W * i_cmd.chunk));
        end
        if (i_cmd.mstore) begin
            case (i_cmd.mul_sel)
                MS_RADIUS: begin
                    r_rad <= $signed({{(RAD_W-SMP_W){r_r_first[SMP_W-1]}}, r_r_first})
                           + $signed({{(RAD_W-RP_W){1'b0}}, r_acc[RP_W-1:0]});
                end
                MS_T: begin
                    r_sat1  <= (r_acc > C_TERM_LIM);
                    r_term1 <= r_d2_neg ? -$signed(w_p) : $signed(w_p);
                end
                default: ;
            endcase
        end
    end

    // restoring divider: |d1|*inv_h / (2*|r|), one quotient bit per beat
    always_comb begin
        w_rad_abs = r_rad[RAD_W-1] ? RAD_W'(-r_rad) : RAD_W'(r_rad);
        w_sh      = {r_rem, r_quo[QUO_W-1]};
        w_diff    = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dload) begin
            r_den <= {w_rad_abs[RMAG_W-1:0], 1'b0};
            r_quo <= r_acc[QUO_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.dstep) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_diff[DEN_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DEN_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_term2 = (r_d1_neg ^ r_rad[RAD_W-1]) ? -$signed(r_quo) : $signed(r_quo);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= r_term1 + w_term2;
        end
    end

    always_comb begin
        w_sum_ok = (r_sum[TERM_W-1:SMP_W-1] == '0) || (r_sum[TERM_W-1:SMP_W-1] == '1);
        if (r_rad == '0) begin
            w_res_val = r_d1_neg ? C_SAT_MIN : C_SAT_MAX;
            w_res_sat = 1'b1;
        end else if (!w_sum_ok) begin
            w_res_val = r_sum[TERM_W-1] ? C_SAT_MIN : C_SAT_MAX;
            w_res_sat = 1'b1;
        end else begin
            w_res_val = r_sum[SMP_W-1:0];
            w_res_sat = r_sat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_res || i_cmd.load_end) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_end) begin
            o_lap_value    <= '0;
            o_result_index <= r_end_idx;
            o_line_end     <= 1'b1;
            o_saturated    <= 1'b0;
        end else if (i_cmd.load_res) begin
            o_line_end <= 1'b0;
            if (r_prev_zero) begin
                o_lap_value    <= '0;
                o_result_index <= '0;
                o_saturated    <= 1'b0;
            end else begin
                o_lap_value    <= w_res_val;
                o_result_index <= r_idx;
                o_saturated    <= w_res_sat;
            end
        end
    end

endmodule
`default_nettype wire

### design/radial_laplacian_stencil_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radial_laplacian_stencil_top
// Radial Laplacian over a three-sample window, Q16.16, saturating.
// Interior beat: four chunked multiplies, the radix-2 divider and a sum, then
// the result beat; input ready again once it is loaded (or after the line-end
// beat too when the line ends there). End-point beats skip the arithmetic and
// go straight to their result or line-end beat.
// Reset: synchronous, active low; config to defaults, window and count clear.
// ----------------------------------------------------------------------------
module radial_laplacian_stencil_top
    import rls_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [SMP_W-1:0]      i_sample,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SMP_W-1:0]           o_lap_value,
    output logic [IDX_W-1:0]           o_result_index,
    output logic                       o_line_end,
    output logic                       o_saturated
);

    t_cmd    w_cmd;
    t_status w_status;

    rls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rls_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_lap_value    (o_lap_value),
        .o_result_index (o_result_index),
        .o_line_end     (o_line_end),
        .o_saturated    (o_saturated)
    );

endmodule
`default_nettype wire

### design/rls_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_checker
// Port-level checks for the radial Laplacian stencil, bound to the top.
// ----------------------------------------------------------------------------
module rls_checker
    import rls_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic [SMP_W-1:0]      i_sample,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [SMP_W-1:0]      o_lap_value,
    input wire logic [IDX_W-1:0]      o_result_index,
    input wire logic                  o_line_end,
    input wire logic                  o_saturated
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_lap_value)
            && $stable(o_result_index) && $stable(o_line_end) && $stable(o_saturated))
        else $error("result beat changed while stalled");

    // end point beats are plain zero
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> (o_lap_value == '0) && !o_saturated)
        else $error("line end beat not zero");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_index == '0) |-> (o_lap_value == '0) && !o_saturated)
        else $error("index zero beat not zero");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind radial_laplacian_stencil_top rls_checker u_rls_checker (.*);
`default_nettype wire

### sim/radial_lap_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radial_lap_checker
// Watches the register port and both beat channels of the radial Laplacian
// stencil, predicts every result from the accepted samples, and compares the
// results in order, field by field. Reports the outstanding and failed counts.
// ----------------------------------------------------------------------------
module radial_lap_checker
    import rls_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [SMP_W-1:0]      i_sample,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [SMP_W-1:0]      i_lap_value,
    input  wire logic [IDX_W-1:0]      i_result_index,
    input  wire logic                  i_line_end,
    input  wire logic                  i_saturated,
    output int                         o_pending,
    output int                         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           FRAC       = 16;
    localparam int unsigned  LINE_CAP   = 65536;
    localparam logic [127:0] TERM_LIMIT = 128'd1 << 62;
    localparam longint       LAP_MAX    = 64'sd2147483647;
    localparam longint       LAP_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] lap_value;
        logic [15:0] result_index;
        logic        line_end;
        logic        saturated;
    } t_lap_result;

    logic [30:0]        inv_h_q;
    logic signed [31:0] r_first_q;
    logic [30:0]        r_step_q;
    logic [16:0]        n_points_q;
    logic signed [31:0] older_smp;
    logic signed [31:0] middle_smp;
    int unsigned        next_index;
    t_lap_result        expected_laps[$];
    int                 mismatches = 0;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic int unsigned line_length(logic [16:0] np);
        int unsigned len;
        len = np;
        if (len == 0) len = 1;
        if (len > LINE_CAP) len = LINE_CAP;
        return len;
    endfunction

    function automatic t_lap_result interior_lap(longint fm, longint f0, longint fp,
                                                 int unsigned idx);
        t_lap_result  res;
        longint       d2, d1, rad, term1, term2, acc;
        logic [127:0] ih, t, p, q;
        res = '0;
        res.result_index = idx[15:0];
        d2  = fm + fp - 2 * f0;
        d1  = fp - fm;
        rad = longint'(r_first_q) + longint'(idx) * longint'(r_step_q);
        ih  = 128'(inv_h_q);
        if (rad == 0) begin
            res.saturated = 1'b1;
            acc = (d1 < 0) ? LAP_MIN : LAP_MAX;
        end else begin
            t = (128'(magnitude(d2)) * ih) >> FRAC;
            if (ih != 0 && t > TERM_LIMIT / ih) begin
                p = TERM_LIMIT;
                res.saturated = 1'b1;
            end else begin
                p = (t * ih) >> FRAC;
                if (p > TERM_LIMIT) begin
                    p = TERM_LIMIT;
                    res.saturated = 1'b1;
                end
            end
            term1 = (d2 < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
            q = (128'(magnitude(d1)) * ih) / (128'(magnitude(rad)) << 1);
            term2 = ((d1 < 0) != (rad < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
            acc = term1 + term2;
            if (acc > LAP_MAX) begin
                acc = LAP_MAX;
                res.saturated = 1'b1;
            end else if (acc < LAP_MIN) begin
                acc = LAP_MIN;
                res.saturated = 1'b1;
            end
        end
        res.lap_value = acc[31:0];
        return res;
    endfunction

    // an accepted sample other than a line's first yields the result one index
    // back, plus the closing zero when it is the last sample of the line
    task automatic predict_laps(logic [31:0] smp);
        int unsigned len, cnt;
        t_lap_result res;
        len = line_length(n_points_q);
        cnt = next_index;
        if (cnt >= len) cnt = 0;
        if (cnt >= 1) begin
            if (cnt == 1) begin
                res = '0;
            end else begin
                res = interior_lap(longint'(older_smp), longint'(middle_smp),
                                   longint'($signed(smp)), cnt - 1);
            end
            expected_laps.push_back(res);
        end
        if (cnt == len - 1) begin
            res = '0;
            res.result_index = cnt[15:0];
            res.line_end = 1'b1;
            expected_laps.push_back(res);
            next_index = 0;
        end else begin
            next_index = cnt + 1;
        end
        older_smp  = middle_smp;
        middle_smp = smp;
    endtask

    task automatic compare_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_lap_result got, want;
        if (!i_rst_n) begin
            inv_h_q    = 31'd65536;
            r_first_q  = '0;
            r_step_q   = 31'd65536;
            n_points_q = 17'd1024;
            older_smp  = '0;
            middle_smp = '0;
            next_index = 0;
            expected_laps.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_INV_H:    inv_h_q    = i_cfg_data[30:0];
                    CFG_R_FIRST:  r_first_q  = i_cfg_data;
                    CFG_R_STEP:   r_step_q   = i_cfg_data[30:0];
                    CFG_N_POINTS: n_points_q = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_laps(i_sample);
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_lap_value, i_result_index, i_line_end, i_saturated};
                if (expected_laps.size() == 0) begin
                    $display("%0t unexpected beat: expected none actual lap %0d index %0d",
                             $time, $signed(got.lap_value), got.result_index);
                    mismatches++;
                end else begin
                    want = expected_laps.pop_front();
                    compare_field("lap_value", longint'($signed(want.lap_value)),
                                  longint'($signed(got.lap_value)));
                    compare_field("result_index", want.result_index, got.result_index);
                    compare_field("line_end", want.line_end, got.line_end);
                    compare_field("saturated", want.saturated, got.saturated);
                end
            end
        end
        o_pending    <= expected_laps.size();
        o_mismatches <= mismatches;
    end

endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Drives the radial Laplacian stencil with directed lines (field extremes,
// zero radius, zero inv_h, short and capped line lengths, length cut
// mid-line) and then random register settings with random samples under
// random stalls on both sides. The checker judges every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rls_pkg::*;

    localparam int RAND_SAMPLES   = 1400;
    localparam int QUIET_CYCLES   = 120;
    localparam int LONG_HOLD      = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int GAPLESS_TAIL   = 200;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [SMP_W-1:0]      i_sample   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SMP_W-1:0]      o_lap_value;
    logic [IDX_W-1:0]      o_result_index;
    logic                  o_line_end;
    logic                  o_saturated;

    int                    pending_laps;
    int                    lap_mismatches;
    bit                    gaps_on      = 1'b1;
    bit                    hold_request = 1'b0;
    int                    samples_sent = 0;
    logic [SMP_W-1:0]      directed_q[$];

    always #5 i_clk = ~i_clk;

    radial_laplacian_stencil_top DUT (.*);

    radial_lap_checker lap_check (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_in_valid,
        .i_in_ready     (o_in_ready),
        .i_sample,
        .i_out_valid    (o_out_valid),
        .i_out_ready,
        .i_lap_value    (o_lap_value),
        .i_result_index (o_result_index),
        .i_line_end     (o_line_end),
        .i_saturated    (o_saturated),
        .o_pending      (pending_laps),
        .o_mismatches   (lap_mismatches)
    );

    // result side: short random stalls, one long hold-off on request
    initial begin : sink_pacing
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[radial_laplacian_stencil_top] ERROR");
        $finish;
    end

    task automatic push_sample(input logic [SMP_W-1:0] smp);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
    endtask

    task automatic push_directed();
        while (directed_q.size() != 0) begin
            push_sample(directed_q.pop_front());
        end
    endtask

    // the first sample of a line gives no beat; wait until no beat is outstanding
    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_laps != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] ih, rf, rs, np);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INV_H;
        i_cfg_data <= ih;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_R_FIRST;
        i_cfg_data <= rf;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_R_STEP;
        i_cfg_data <= rs;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_N_POINTS;
        i_cfg_data <= np;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] ih, rf, rs, np;
        ih = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4 * 65536);
        rs = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4 * 65536);
        case ($urandom_range(0, 3))
            0:       rf = $urandom();
            // radius crosses zero at a small index
            1:       rf = 32'(-(longint'($urandom_range(1, 8)) * longint'(rs[30:0])));
            default: rf = $urandom_range(0, 8 * 65536) - 4 * 65536;
        endcase
        case ($urandom_range(0, 7))
            0:       np = $urandom();
            1:       np = $urandom_range(0, 1);
            default: np = $urandom_range(2, 40);
        endcase
        load_config(ih, rf, rs, np);
    endtask

    initial begin : stimulus
        int phase_len;
        int phase_no;
        int rand_goal;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: unit spacing, radius equals index
        directed_q = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                       32'hFFFF_FFFF};
        push_directed();
        drain_block();

        // widest inv_h, zero radius at index 2, two lines of five
        load_config(32'hFFFF_FFFF, 32'hFFFE_0000, 32'h8001_0000, 32'd5);
        directed_q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                       32'h8000_0000, 32'h0000_0003};
        push_directed();
        drain_block();

        // zero inv_h, zero length: one sample per line
        load_config(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        directed_q = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF};
        push_directed();
        drain_block();

        // smallest inv_h and step, most negative first radius
        load_config(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'd3);
        directed_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000};
        push_directed();
        drain_block();

        // length above the cap, then cut mid-line
        load_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_FFFF);
        directed_q = '{32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0300};
        push_directed();
        drain_block();
        load_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd2);
        directed_q = '{32'h0000_0007, 32'h0000_0009};
        push_directed();
        drain_block();

        phase_no  = 0;
        rand_goal = samples_sent + RAND_SAMPLES;
        while (samples_sent < rand_goal) begin
            random_settings();
            if (phase_no == 2) hold_request = 1'b1;
            phase_len = $urandom_range(40, 140);
            repeat (phase_len) begin
                if (rand_goal - samples_sent <= GAPLESS_TAIL) gaps_on = 1'b0;
                push_sample(pick_sample());
            end
            drain_block();
            phase_no++;
        end

        if (lap_mismatches == 0 && pending_laps == 0) begin
            $display("[radial_laplacian_stencil_top] OK");
        end else begin
            $display("[radial_laplacian_stencil_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
